[rtl/page_table_uncached_mapper_assert.svh]
// Assertion macros for the page table uncached mapper.
`ifndef PAGE_TABLE_UNCACHED_MAPPER_ASSERT_SVH
`define PAGE_TABLE_UNCACHED_MAPPER_ASSERT_SVH
`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define PTUM_ASSERT(label_, clk_, rstn_, prop_) \
  label_: assert property (@(posedge clk_) disable iff (!rstn_) (prop_)) \
    else $error("ptum assertion failed");
// Consequence holds in the cycle after the trigger.
`define PTUM_ASSERT_NEXT(label_, clk_, rstn_, ante_, cons_) \
  label_: assert property (@(posedge clk_) disable iff (!rstn_) (ante_) |=> (cons_)) \
    else $error("ptum assertion failed");
`else
`define PTUM_ASSERT(label_, clk_, rstn_, prop_)
`define PTUM_ASSERT_NEXT(label_, clk_, rstn_, ante_, cons_)
`endif
`endif

[rtl/ptum_pkg.sv]
// Shared types and constants for the page table uncached mapper.
`timescale 1ns / 1ps
package ptum_pkg;

  localparam int TablePages    = 64;
  localparam int EntriesPerTbl = 512;
  localparam int IdxW          = 9;

  // result status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StEmpty   = 3'd1;
  localparam logic [2:0] StWrap    = 3'd2;
  localparam logic [2:0] StNoPages = 3'd3;
  localparam logic [2:0] StBadPtr  = 3'd4;

  // request kinds
  localparam logic [1:0] KindLookup = 2'd0;
  localparam logic [1:0] KindMap    = 2'd1;
  localparam logic [1:0] KindRaw    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] address;
    logic [63:0] size;
    logic [5:0]  table_page;
    logic [8:0]  entry_index;
    logic [63:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry;
    logic [63:0] mapped_address;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ROOTCLR, OP_MSUM, OP_MINIT, OP_RD4, OP_RD3, OP_RD2,
    OP_LATCH, OP_SETPG, OP_GRAB, OP_FILL, OP_LINK, OP_WRLEAF, OP_NEXT,
    OP_RAW, OP_DONE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] code;
    logic       ent_sel;
    logic       map_ok;
    logic       fill_split;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       size_zero;
    logic       wraps;
    logic       rd_p;
    logic       rd_ps;
    logic       tp_ok;
    logic       nfp_ok;
    logic       blk_full;
    logic       last_hit;
    logic       cnt_last;
    logic       tpage_ok;
  } stat_t;

endpackage

[rtl/page_table_uncached_mapper.sv]
// Top level of the page table uncached mapper.
`timescale 1ns / 1ps
// Accepts a word when start is high and busy is low; one result word follows on
// rsp_o with done_o high for one cycle, and it must be taken then. All table
// accesses go through one single-port store, one access per cycle. After reset
// busy stays high while the root page is cleared. A lookup makes up to three
// dependent reads. A map handles one 2 MiB block per pass and writes each new
// table page, whether cleared or split from a 1 GiB page, entry by entry.
module page_table_uncached_mapper #(
  parameter int TABLE_PAGES = ptum_pkg::TablePages
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [51:0]    cfg_wdata_i,
  input  logic           start,
  output logic           busy,
  input  ptum_pkg::req_t req_i,
  output logic           done_o,
  output ptum_pkg::rsp_t rsp_o
);
  ptum_pkg::cmd_t  cmd;
  ptum_pkg::stat_t stat;

  ptum_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy  (busy)
  );

  ptum_datapath #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );
endmodule

[rtl/ptum_datapath.sv]
// Datapath: table store, walk registers, allocator and result register.
`timescale 1ns / 1ps
module ptum_datapath #(
  parameter int TABLE_PAGES = ptum_pkg::TablePages
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [51:0]     cfg_wdata_i,
  input  ptum_pkg::req_t  req_i,
  input  ptum_pkg::cmd_t  cmd_i,
  output ptum_pkg::stat_t stat_o,
  output logic            done_o,
  output ptum_pkg::rsp_t  rsp_o
);
  localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int AW    = PW + ptum_pkg::IdxW;
  localparam int DEPTH = TABLE_PAGES * ptum_pkg::EntriesPerTbl;
  localparam int BW    = $clog2(DEPTH) + 1;

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;

  logic [51:0]   base_q;
  logic [63:0]   addr_q, szm1_q, val_q, a_q, ent_q;
  logic          size_zero_q;
  logic [1:0]    kind_q;
  logic [5:0]    tpage_q;
  logic [8:0]    idx_q, cnt_q;
  logic [64:0]   end_q;
  logic [42:0]   last_q;
  logic [PW-1:0] pg_q, np_q;
  logic [PW:0]   nfp_q;
  logic [BW-1:0] blocks_q;
  logic [AW-1:0] slot_q;
  logic          done_q;
  ptum_pkg::rsp_t rsp_q;

  logic          we, re, tpage_ok, tp_ok;
  logic [AW-1:0] wa, ra;
  logic [63:0]   wd, fill_d;
  logic [40:0]   pdiff;
  logic [40:0]   tsum;

  // table pointer to page number
  assign pdiff    = {1'b0, ent_q[51:12]} - {1'b0, base_q[51:12]};
  assign tp_ok    = !pdiff[40] && (pdiff[39:0] < 40'(TABLE_PAGES));
  assign tpage_ok = 13'(tpage_q) < 13'(TABLE_PAGES);
  // new page address may carry past bit 51
  assign tsum     = 41'(base_q[51:12]) + 41'(np_q);
  // split entries keep P, RW, PWT, PCD of the 1 GiB page
  assign fill_d   = cmd_i.fill_split ?
                    ({12'b0, ent_q[51:30], cnt_q, 21'b0} | (ent_q & 64'h1B) | 64'h80) :
                    64'b0;

  // memory port selection
  always_comb begin
    we = 1'b0; wa = '0; wd = '0;
    re = 1'b0; ra = '0;
    case (cmd_i.op)
      ptum_pkg::OP_ROOTCLR: begin we = 1'b1; wa = {PW'(0), cnt_q}; end
      ptum_pkg::OP_FILL:    begin we = 1'b1; wa = {np_q, cnt_q}; wd = fill_d; end
      ptum_pkg::OP_LINK:    begin we = 1'b1; wa = slot_q; wd = {11'b0, tsum, 12'h003}; end
      ptum_pkg::OP_WRLEAF:  begin
        we = 1'b1; wa = {pg_q, a_q[29:21]}; wd = a_q | 64'h9B;
      end
      ptum_pkg::OP_RAW:     begin we = tpage_ok; wa = {PW'(tpage_q), idx_q}; wd = val_q; end
      ptum_pkg::OP_RD4:     begin re = 1'b1; ra = {PW'(0), a_q[47:39]}; end
      ptum_pkg::OP_RD3:     begin re = 1'b1; ra = {pg_q, a_q[38:30]}; end
      ptum_pkg::OP_RD2:     begin re = 1'b1; ra = {pg_q, a_q[29:21]}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rdata_q <= mem[ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cnt_q  <= '0;
      nfp_q  <= (PW+1)'(1);
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= {cfg_wdata_i[51:12], 12'b0};
      done_q <= (cmd_i.op == ptum_pkg::OP_DONE);
      case (cmd_i.op)
        ptum_pkg::OP_ROOTCLR, ptum_pkg::OP_FILL: cnt_q <= cnt_q + 9'd1;
        ptum_pkg::OP_GRAB: begin cnt_q <= '0; nfp_q <= nfp_q + (PW+1)'(1); end
        default: ;
      endcase
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ptum_pkg::OP_LOAD: begin
        kind_q <= req_i.kind; addr_q <= req_i.address; a_q <= req_i.address;
        szm1_q <= req_i.size - 64'd1; size_zero_q <= (req_i.size == 64'd0);
        tpage_q <= req_i.table_page; idx_q <= req_i.entry_index;
        val_q <= req_i.entry_value;
      end
      ptum_pkg::OP_MSUM:  end_q <= {1'b0, addr_q} + {1'b0, szm1_q};
      ptum_pkg::OP_MINIT: begin
        a_q <= {addr_q[63:21], 21'b0}; last_q <= end_q[63:21]; blocks_q <= '0;
      end
      ptum_pkg::OP_RD4:   begin blocks_q <= blocks_q + BW'(1); slot_q <= ra; end
      ptum_pkg::OP_RD3, ptum_pkg::OP_RD2: slot_q <= ra;
      ptum_pkg::OP_LATCH: ent_q <= rdata_q;
      ptum_pkg::OP_SETPG: pg_q <= pdiff[PW-1:0];
      ptum_pkg::OP_GRAB:  np_q <= nfp_q[PW-1:0];
      ptum_pkg::OP_LINK:  ent_q <= {11'b0, tsum, 12'h003};
      ptum_pkg::OP_NEXT:  a_q <= a_q + 64'h20_0000;
      ptum_pkg::OP_DONE:  begin
        rsp_q.status         <= cmd_i.code;
        rsp_q.entry          <= cmd_i.ent_sel ? rdata_q : 64'b0;
        rsp_q.mapped_address <= cmd_i.map_ok ? addr_q : 64'b0;
      end
      default: ;
    endcase
  end

  assign stat_o.kind      = kind_q;
  assign stat_o.size_zero = size_zero_q;
  assign stat_o.wraps     = end_q[64];
  assign stat_o.rd_p      = rdata_q[0];
  assign stat_o.rd_ps     = rdata_q[7];
  assign stat_o.tp_ok     = tp_ok;
  assign stat_o.nfp_ok    = nfp_q < (PW+1)'(TABLE_PAGES);
  assign stat_o.blk_full  = blocks_q >= BW'(DEPTH);
  assign stat_o.last_hit  = (a_q[63:21] == last_q);
  assign stat_o.cnt_last  = &cnt_q;
  assign stat_o.tpage_ok  = tpage_ok;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;
endmodule

[rtl/ptum_ctrl.sv]
// Controller state machine sequencing lookups, maps and raw writes.
`timescale 1ns / 1ps
`include "page_table_uncached_mapper_assert.svh"
module ptum_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  ptum_pkg::stat_t stat_i,
  output ptum_pkg::cmd_t  cmd_o,
  output logic            busy
);
  typedef enum logic [26:0] {
    S_IDLE  = 27'd1 << 0,  S_RCLR  = 27'd1 << 1,  S_DISP  = 27'd1 << 2,
    S_L_RD4 = 27'd1 << 3,  S_L_CK4 = 27'd1 << 4,  S_L_TP4 = 27'd1 << 5,
    S_L_RD3 = 27'd1 << 6,  S_L_CK3 = 27'd1 << 7,  S_L_TP3 = 27'd1 << 8,
    S_L_RD2 = 27'd1 << 9,  S_L_CK2 = 27'd1 << 10, S_M_SUM = 27'd1 << 11,
    S_M_DEC = 27'd1 << 12, S_M_BLK = 27'd1 << 13, S_M_CK4 = 27'd1 << 14,
    S_M_TP4 = 27'd1 << 15, S_M_RD3 = 27'd1 << 16, S_M_CK3 = 27'd1 << 17,
    S_M_TP3 = 27'd1 << 18, S_M_WR2 = 27'd1 << 19, S_M_NX  = 27'd1 << 20,
    S_GRAB  = 27'd1 << 21, S_FILL  = 27'd1 << 22, S_LINK  = 27'd1 << 23,
    S_RAW   = 27'd1 << 24, S_R_FIN = 27'd1 << 25, S_M_RD4 = 27'd1 << 26
  } state_e;

  state_e state_q, state_d;
  logic   split_q, split_d, lvl3_q, lvl3_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RCLR;
      split_q <= 1'b0;
      lvl3_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      split_q <= split_d;
      lvl3_q  <= lvl3_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d = state_q;
    split_d = split_q;
    lvl3_d  = lvl3_q;
    cmd_o   = '{op: ptum_pkg::OP_NONE, code: ptum_pkg::StOk,
                ent_sel: 1'b0, map_ok: 1'b0, fill_split: split_q};
    case (state_q)
      S_IDLE: if (start) begin cmd_o.op = ptum_pkg::OP_LOAD; state_d = S_DISP; end
      S_RCLR: begin
        cmd_o.op = ptum_pkg::OP_ROOTCLR;
        if (stat_i.cnt_last) state_d = S_IDLE;
      end
      S_DISP: begin
        case (stat_i.kind)
          ptum_pkg::KindLookup: state_d = S_L_RD4;
          ptum_pkg::KindMap:    state_d = S_M_SUM;
          ptum_pkg::KindRaw:    state_d = S_RAW;
          default: begin cmd_o.op = ptum_pkg::OP_DONE; state_d = S_IDLE; end
        endcase
      end
      // lookup walk
      S_L_RD4: begin cmd_o.op = ptum_pkg::OP_RD4; state_d = S_L_CK4; end
      S_L_CK4: begin
        if (!stat_i.rd_p) begin cmd_o.op = ptum_pkg::OP_DONE; state_d = S_IDLE; end
        else begin cmd_o.op = ptum_pkg::OP_LATCH; state_d = S_L_TP4; end
      end
      S_L_TP4: begin
        if (!stat_i.tp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StBadPtr; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_SETPG; state_d = S_L_RD3; end
      end
      S_L_RD3: begin cmd_o.op = ptum_pkg::OP_RD3; state_d = S_L_CK3; end
      S_L_CK3: begin
        if (!stat_i.rd_p || stat_i.rd_ps) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.ent_sel = stat_i.rd_p; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_LATCH; state_d = S_L_TP3; end
      end
      S_L_TP3: begin
        if (!stat_i.tp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StBadPtr; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_SETPG; state_d = S_L_RD2; end
      end
      S_L_RD2: begin cmd_o.op = ptum_pkg::OP_RD2; state_d = S_L_CK2; end
      S_L_CK2: begin
        cmd_o.op = ptum_pkg::OP_DONE; cmd_o.ent_sel = stat_i.rd_p; state_d = S_IDLE;
      end
      // map: range checks
      S_M_SUM: begin cmd_o.op = ptum_pkg::OP_MSUM; state_d = S_M_DEC; end
      S_M_DEC: begin
        if (stat_i.size_zero) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StEmpty; state_d = S_IDLE;
        end else if (stat_i.wraps) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StWrap; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_MINIT; state_d = S_M_BLK; end
      end
      // map: one 2 MiB block per pass
      S_M_BLK: begin
        if (stat_i.blk_full) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StNoPages; state_d = S_IDLE;
        end else state_d = S_M_RD4;
      end
      S_M_RD4: begin cmd_o.op = ptum_pkg::OP_RD4; state_d = S_M_CK4; end
      S_M_CK4: begin
        if (stat_i.rd_p) begin cmd_o.op = ptum_pkg::OP_LATCH; state_d = S_M_TP4; end
        else if (!stat_i.nfp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StNoPages; state_d = S_IDLE;
        end else begin
          cmd_o.op = ptum_pkg::OP_LATCH; split_d = 1'b0; lvl3_d = 1'b0; state_d = S_GRAB;
        end
      end
      S_M_TP4: begin
        if (!stat_i.tp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StBadPtr; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_SETPG; state_d = S_M_RD3; end
      end
      S_M_RD3: begin cmd_o.op = ptum_pkg::OP_RD3; state_d = S_M_CK3; end
      S_M_CK3: begin
        if (stat_i.rd_p && !stat_i.rd_ps) begin
          cmd_o.op = ptum_pkg::OP_LATCH; state_d = S_M_TP3;
        end else if (!stat_i.nfp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StNoPages; state_d = S_IDLE;
        end else begin
          cmd_o.op = ptum_pkg::OP_LATCH; split_d = stat_i.rd_p; lvl3_d = 1'b1;
          state_d = S_GRAB;
        end
      end
      S_M_TP3: begin
        if (!stat_i.tp_ok) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.code = ptum_pkg::StBadPtr; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_SETPG; state_d = S_M_WR2; end
      end
      S_M_WR2: begin cmd_o.op = ptum_pkg::OP_WRLEAF; state_d = S_M_NX; end
      S_M_NX: begin
        if (stat_i.last_hit) begin
          cmd_o.op = ptum_pkg::OP_DONE; cmd_o.map_ok = 1'b1; state_d = S_IDLE;
        end else begin cmd_o.op = ptum_pkg::OP_NEXT; state_d = S_M_BLK; end
      end
      // page allocation: clear or split fill, then link into parent
      S_GRAB: begin cmd_o.op = ptum_pkg::OP_GRAB; state_d = S_FILL; end
      S_FILL: begin
        cmd_o.op = ptum_pkg::OP_FILL;
        if (stat_i.cnt_last) state_d = S_LINK;
      end
      S_LINK: begin
        cmd_o.op = ptum_pkg::OP_LINK;
        state_d  = lvl3_q ? S_M_TP3 : S_M_TP4;
      end
      // raw entry write
      S_RAW: begin cmd_o.op = ptum_pkg::OP_RAW; state_d = S_R_FIN; end
      S_R_FIN: begin
        cmd_o.op   = ptum_pkg::OP_DONE;
        cmd_o.code = stat_i.tpage_ok ? ptum_pkg::StOk : ptum_pkg::StBadPtr;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  `PTUM_ASSERT(a_grab_has_page, clk_i, rst_ni, (state_q != S_GRAB) || stat_i.nfp_ok)
  `PTUM_ASSERT_NEXT(a_fill_to_link, clk_i, rst_ni, (state_q == S_FILL) && stat_i.cnt_last, state_q == S_LINK)
  `PTUM_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, cmd_o.op == ptum_pkg::OP_DONE, state_q == S_IDLE)
endmodule
